// ===== sv/qpm_pkg.sv =====
// Shared widths, constants and product tables for the quaternion pose mirror.
`default_nettype none

package qpm_pkg;

  // component format, signed Q2.14
  localparam int CW = 16;
  localparam int RND = 14;

  // widths of the intermediate Hamilton products
  localparam int Q1W = 2 * CW + 2;
  localparam int Q2W = Q1W + CW + 2 - RND;
  localparam int Q3W = Q2W + CW + 2 - RND;
  localparam int Q4W = Q3W + CW + 2 - RND;

  // stages in one Hamilton product unit
  localparam int HP_LAT = 3;

  // normalization widths
  localparam int MAGW = 30;
  localparam int SHW = 5;
  localparam int SQW = 2 * MAGW;
  localparam int SUMW = SQW + 2;
  localparam int ROOTW = SUMW / 2;
  localparam int QUOW = 16;
  localparam int NUMW = MAGW + CW;

  localparam logic [SUMW-1:0] NEAR_ZERO = SUMW'(720575940);

  typedef logic signed [CW-1:0] comp_t;

  localparam comp_t ONE_Q14 = 16'sh4000;
  localparam comp_t Q_MAX = 16'sh7FFF;
  localparam comp_t Q_MIN = 16'sh8000;

  // mirror axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;
  localparam logic [1:0] AXIS_RESET = AXIS_Y;

  // Hamilton product terms, term t = 4 * component + j
  localparam int HP_IA [16] = '{0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3, 0, 1, 2, 3};
  localparam int HP_IB [16] = '{0, 1, 2, 3, 1, 0, 3, 2, 2, 3, 0, 1, 3, 2, 1, 0};
  localparam logic [15:0] HP_NEG = 16'h428E;

  // side data carried alongside the norm through the root and divide units
  typedef struct packed {
    logic                      near;
    logic [3:0]                neg;
    logic [3:0][MAGW-1:0]      mag;
  } nrm_side_t;

endpackage

`default_nettype wire

// ===== sv/qpm_hprod.sv =====
// Pipelined Hamilton product of two quaternions with optional conjugates and rounding.
`default_nettype none

module qpm_hprod #(
  parameter int AW = qpm_pkg::CW,
  parameter int BW = qpm_pkg::CW,
  parameter int RSH = 0,
  parameter bit CONJ_A = 1'b0,
  parameter bit CONJ_B = 1'b0,
  localparam int OW = AW + BW + 2 - RSH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic signed [AW-1:0] a [4],
  input  wire logic signed [BW-1:0] b [4],
  output logic                      out_valid,
  output logic signed [OW-1:0]      r [4]
);

  localparam int PW = AW + BW;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] RADD = SW'((64'd1 << RSH) >> 1);

  logic [qpm_pkg::HP_LAT-1:0] vld;
  logic signed [PW-1:0] prod [16];
  logic [15:0]          negf;
  logic signed [SW-1:0] pair [8];

  // advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[qpm_pkg::HP_LAT-2:0], in_valid};
    end
  end

  // form all sixteen partial products
  for (genvar t = 0; t < 16; t++) begin : g_prod
    localparam int IA = qpm_pkg::HP_IA[t];
    localparam int IB = qpm_pkg::HP_IB[t];
    localparam bit NG = qpm_pkg::HP_NEG[t] ^ (CONJ_A && (IA != 0)) ^ (CONJ_B && (IB != 0));
    logic signed [PW-1:0] ax;
    logic signed [PW-1:0] bx;
    assign ax = PW'(a[IA]);
    assign bx = PW'(b[IB]);
    assign negf[t] = NG;
    always_ff @(posedge clk) begin
      if (en) begin
        prod[t] <= ax * bx;
      end
    end
  end

  // add signed pairs of terms
  for (genvar h = 0; h < 8; h++) begin : g_pair
    logic signed [SW-1:0] e0;
    logic signed [SW-1:0] e1;
    assign e0 = negf[2*h] ? -SW'(prod[2*h]) : SW'(prod[2*h]);
    assign e1 = negf[2*h+1] ? -SW'(prod[2*h+1]) : SW'(prod[2*h+1]);
    always_ff @(posedge clk) begin
      if (en) begin
        pair[h] <= e0 + e1;
      end
    end
  end

  // finish the sum and round half up
  for (genvar k = 0; k < 4; k++) begin : g_sum
    logic signed [SW-1:0] tot;
    assign tot = pair[2*k] + pair[2*k+1] + RADD;
    always_ff @(posedge clk) begin
      if (en) begin
        r[k] <= OW'(tot >>> RSH);
      end
    end
  end

  assign out_valid = vld[qpm_pkg::HP_LAT-1];

endmodule

`default_nettype wire

// ===== sv/qpm_norm.sv =====
// Magnitude, range shift, sum of squares and near-zero test of the mirrored rotation.
`default_nettype none

module qpm_norm (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic signed [qpm_pkg::Q4W-1:0]    m [4],
  output logic                                   out_valid,
  output logic [qpm_pkg::SUMW-1:0]               sum,
  output qpm_pkg::nrm_side_t                     side
);

  localparam int NST = 7;
  localparam int MW = qpm_pkg::Q4W;
  localparam int MAGW = qpm_pkg::MAGW;

  logic [NST-1:0] vld;

  logic [MW-1:0]   mag1 [4];
  logic [MW-1:0]   mag2 [4];
  logic [MAGW-1:0] mag3 [4];
  logic [MAGW-1:0] mag4 [4];
  logic [MAGW-1:0] mag5 [4];
  logic [MAGW-1:0] mag6 [4];
  logic [3:0]      neg1, neg2, neg3, neg4, neg5, neg6;
  logic [qpm_pkg::SHW-1:0] sh2;
  logic            shz3, shz4, shz5, shz6;
  logic [qpm_pkg::SQW-1:0]  sq4 [4];
  logic [qpm_pkg::SQW:0]    pr5 [2];
  logic [qpm_pkg::SUMW-1:0] tot6;
  logic [MW-1:0]   orv;
  logic [qpm_pkg::SHW-1:0] sh_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // find the shift that brings the largest magnitude below the range limit
  always_comb begin
    orv = mag1[0] | mag1[1] | mag1[2] | mag1[3];
    sh_c = '0;
    for (int j = 0; j < MW - MAGW; j++) begin
      if (orv[MAGW+j]) begin
        sh_c = qpm_pkg::SHW'(j + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // take magnitudes
      for (int i = 0; i < 4; i++) begin
        neg1[i] <= m[i][MW-1];
        mag1[i] <= m[i][MW-1] ? MW'(-m[i]) : MW'(m[i]);
      end
      // hold shift amount
      mag2 <= mag1;
      neg2 <= neg1;
      sh2 <= sh_c;
      // shift into range
      for (int i = 0; i < 4; i++) begin
        mag3[i] <= MAGW'(mag2[i] >> sh2);
      end
      neg3 <= neg2;
      shz3 <= (sh2 == '0);
      // square
      for (int i = 0; i < 4; i++) begin
        sq4[i] <= qpm_pkg::SQW'(mag3[i]) * qpm_pkg::SQW'(mag3[i]);
      end
      mag4 <= mag3;
      neg4 <= neg3;
      shz4 <= shz3;
      // add pairs
      pr5[0] <= (qpm_pkg::SQW + 1)'(sq4[0]) + (qpm_pkg::SQW + 1)'(sq4[1]);
      pr5[1] <= (qpm_pkg::SQW + 1)'(sq4[2]) + (qpm_pkg::SQW + 1)'(sq4[3]);
      mag5 <= mag4;
      neg5 <= neg4;
      shz5 <= shz4;
      // finish the sum
      tot6 <= qpm_pkg::SUMW'(pr5[0]) + qpm_pkg::SUMW'(pr5[1]);
      mag6 <= mag5;
      neg6 <= neg5;
      shz6 <= shz5;
      // flag a norm too short to divide by
      sum <= tot6;
      side.near <= shz6 && (tot6 <= qpm_pkg::NEAR_ZERO);
      side.neg <= neg6;
      for (int i = 0; i < 4; i++) begin
        side.mag[i] <= mag6[i];
      end
    end
  end

  assign out_valid = vld[NST-1];

endmodule

`default_nettype wire

// ===== sv/qpm_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module qpm_sqrt #(
  parameter int SBW = $bits(qpm_pkg::nrm_side_t)
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         en,
  input  wire logic                         in_valid,
  input  wire logic [qpm_pkg::SUMW-1:0]     sum,
  input  wire logic [SBW-1:0]               side_in,
  output logic                              out_valid,
  output logic [qpm_pkg::ROOTW-1:0]         root,
  output logic [SBW-1:0]                    side_out
);

  localparam int NW = qpm_pkg::SUMW;
  localparam int RW = NW + 1;
  localparam int NS = qpm_pkg::ROOTW;

  logic [NS-1:0]  vld;
  logic [NW-1:0]  nr [NS];
  logic [RW-1:0]  rr [NS];
  logic [SBW-1:0] sd [NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_stage
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (NS - 1 - g));
    logic [NW-1:0]  n_in;
    logic [RW-1:0]  r_in;
    logic [SBW-1:0] s_in;
    logic [RW-1:0]  trial;
    logic           take;
    if (g == 0) begin : g_first
      assign n_in = sum;
      assign r_in = '0;
      assign s_in = side_in;
    end else begin : g_next
      assign n_in = nr[g-1];
      assign r_in = rr[g-1];
      assign s_in = sd[g-1];
    end
    // try this root bit against the remainder
    assign trial = r_in + BIT;
    assign take = ({1'b0, n_in} >= trial);
    always_ff @(posedge clk) begin
      if (en) begin
        nr[g] <= take ? NW'({1'b0, n_in} - trial) : n_in;
        rr[g] <= take ? (r_in >> 1) + BIT : (r_in >> 1);
        sd[g] <= s_in;
      end
    end
  end

  assign out_valid = vld[NS-1];
  assign root = qpm_pkg::ROOTW'(rr[NS-1]);
  assign side_out = sd[NS-1];

endmodule

`default_nettype wire

// ===== sv/qpm_div.sv =====
// Pipelined restoring division of each magnitude by the norm, then sign and saturation, or identity on a short norm.
`default_nettype none

module qpm_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  wire logic [qpm_pkg::ROOTW-1:0]  root,
  input  wire qpm_pkg::nrm_side_t         side,
  output logic                            out_valid,
  output qpm_pkg::comp_t                  q [4]
);

  localparam int NUMW = qpm_pkg::NUMW;
  localparam int DENW = qpm_pkg::ROOTW + 1;
  localparam int DW = NUMW + 2;
  localparam int QW = qpm_pkg::QUOW;
  localparam int NST = QW + 2;

  logic [NST-1:0]  vld;
  logic [NUMW-1:0] num0 [4];
  logic [DENW-1:0] den0;
  logic [3:0]      neg0;
  logic            near0;

  logic [NUMW-1:0] rem [QW][4];
  logic [QW-1:0]   quo [QW][4];
  logic [DENW-1:0] dd  [QW];
  logic [3:0]      ngd [QW];
  logic            nrd [QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // form m * 2^15 + N over 2N
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        num0[i] <= (NUMW'(side.mag[i]) << (qpm_pkg::CW - 1)) + NUMW'(root);
      end
      den0 <= {root, 1'b0};
      neg0 <= side.neg;
      near0 <= side.near;
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int BP = QW - 1 - j;
    logic [DENW-1:0] d_in;
    logic [3:0]      n_in;
    logic            z_in;
    logic [DW-1:0]   trial;
    if (j == 0) begin : g_first
      assign d_in = den0;
      assign n_in = neg0;
      assign z_in = near0;
    end else begin : g_next
      assign d_in = dd[j-1];
      assign n_in = ngd[j-1];
      assign z_in = nrd[j-1];
    end
    assign trial = DW'(d_in) << BP;
    for (genvar i = 0; i < 4; i++) begin : g_lane
      logic [NUMW-1:0] r_in;
      logic [QW-1:0]   q_in;
      logic            take;
      if (j == 0) begin : g_first
        assign r_in = num0[i];
        assign q_in = '0;
      end else begin : g_next
        assign r_in = rem[j-1][i];
        assign q_in = quo[j-1][i];
      end
      // subtract the shifted divisor where it fits
      assign take = (DW'(r_in) >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          rem[j][i] <= take ? NUMW'(DW'(r_in) - trial) : r_in;
          quo[j][i] <= {q_in[QW-2:0], take};
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        dd[j] <= d_in;
        ngd[j] <= n_in;
        nrd[j] <= z_in;
      end
    end
  end

  // apply sign, saturate, or drop to identity on a short norm
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        if (nrd[QW-1]) begin
          q[i] <= (i == 0) ? qpm_pkg::ONE_Q14 : '0;
        end else if (ngd[QW-1][i]) begin
          q[i] <= quo[QW-1][i][QW-1] ? qpm_pkg::Q_MIN : qpm_pkg::comp_t'(-quo[QW-1][i]);
        end else begin
          q[i] <= (quo[QW-1][i] >= QW'(qpm_pkg::Q_MAX)) ? qpm_pkg::Q_MAX
                                                         : qpm_pkg::comp_t'(quo[QW-1][i]);
        end
      end
    end
  end

  assign out_valid = vld[NST-1];

endmodule

`default_nettype wire

// ===== sv/quaternion_pose_mirror.sv =====
// Mirrored pose of a partner bone: top level with input, config and output channels.
// Usage:
//   s_* carries one item: delta, edited bone reference and partner reference rotations,
//   twelve signed Q2.14 components. m_* returns the normalized mirrored rotation,
//   four signed Q2.14 components. cfg_* writes mirror_axis (0 X, 1 Y, 2 Z); it is
//   always ready and should only be written while no item is in flight.
// Throughput: one item per cycle while s_tready is high. The datapath is a 69-stage
//   pipeline: four three-stage Hamilton product units, a mirror stage, seven stages of
//   magnitude, shift and sum of squares, a 31-stage square root with one root bit per
//   stage and an 18-stage divider with one quotient bit per division stage, then the
//   output register, which drives m_tvalid.
// Reset: clears all valid bits, including those of the output and skid registers, and
//   sets mirror_axis to Y.
// Stall: while m_tready is low the output register holds its item and the next one
//   finishing lands in a skid register; only once that is full does s_tready drop
//   and the whole pipeline freeze, with nothing lost or repeated.
`default_nettype none

module quaternion_pose_mirror (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // delta_w, delta_x, delta_y, delta_z, ref_bone_w, ref_bone_x, ref_bone_y,
  // ref_bone_z, ref_partner_w, ref_partner_x, ref_partner_y, ref_partner_z
  input  wire logic [191:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // out_w, out_x, out_y, out_z
  output logic [63:0]       m_tdata,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_data
);

  localparam int CW = qpm_pkg::CW;
  localparam int QW4 = 4 * CW;
  localparam int RB_TAP = qpm_pkg::HP_LAT - 1;
  localparam int PO_TAP3 = 2 * qpm_pkg::HP_LAT;
  localparam int PO_TAP4 = PO_TAP3 + qpm_pkg::HP_LAT;
  localparam int PO_DEPTH = PO_TAP4 + 1;

  logic en;
  logic [1:0] axis;

  qpm_pkg::comp_t d [4];
  qpm_pkg::comp_t rb [4];
  qpm_pkg::comp_t rb2 [4];
  qpm_pkg::comp_t po3 [4];
  qpm_pkg::comp_t po4 [4];

  logic [QW4-1:0] rb_pipe [RB_TAP+1];
  logic [QW4-1:0] po_pipe [PO_DEPTH];

  logic v1, v2, v3, v4, vm, vn, vs, vd;
  logic signed [qpm_pkg::Q1W-1:0] t1 [4];
  logic signed [qpm_pkg::Q2W-1:0] t2 [4];
  logic signed [qpm_pkg::Q2W-1:0] mir [4];
  logic signed [qpm_pkg::Q3W-1:0] t3 [4];
  logic signed [qpm_pkg::Q4W-1:0] t4 [4];

  logic [qpm_pkg::SUMW-1:0]  nsum;
  qpm_pkg::nrm_side_t        nside;
  qpm_pkg::nrm_side_t        rside;
  logic [qpm_pkg::ROOTW-1:0] root;
  qpm_pkg::comp_t            qo [4];
  logic [QW4-1:0]            pdata;

  logic           o_valid;
  logic [QW4-1:0] o_data;
  logic           sk_valid;
  logic [QW4-1:0] sk_data;

  // the pipeline moves while the skid register is empty
  assign en = !sk_valid;
  assign s_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis <= qpm_pkg::AXIS_RESET;
    end else if (cfg_valid) begin
      axis <= cfg_data;
    end
  end

  // unpack the input item and the delayed reference rotations
  for (genvar i = 0; i < 4; i++) begin : g_unpack
    assign d[i] = s_tdata[CW*i +: CW];
    assign rb[i] = s_tdata[QW4 + CW*i +: CW];
    assign rb2[i] = rb_pipe[RB_TAP][CW*i +: CW];
    assign po3[i] = po_pipe[PO_TAP3][CW*i +: CW];
    assign po4[i] = po_pipe[PO_TAP4][CW*i +: CW];
    assign pdata[CW*i +: CW] = qo[i];
  end

  // delay the reference rotations to meet the products that use them
  always_ff @(posedge clk) begin
    if (en) begin
      rb_pipe[0] <= s_tdata[QW4 +: QW4];
      for (int k = 1; k <= RB_TAP; k++) begin
        rb_pipe[k] <= rb_pipe[k-1];
      end
      po_pipe[0] <= s_tdata[2*QW4 +: QW4];
      for (int k = 1; k < PO_DEPTH; k++) begin
        po_pipe[k] <= po_pipe[k-1];
      end
    end
  end

  // R * D
  qpm_hprod #(.AW(CW), .BW(CW), .RSH(0)) u_prod1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .a(rb), .b(d), .out_valid(v1), .r(t1)
  );

  // (R * D) * conj(R)
  qpm_hprod #(.AW(qpm_pkg::Q1W), .BW(CW), .RSH(qpm_pkg::RND), .CONJ_B(1'b1)) u_prod2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1),
    .a(t1), .b(rb2), .out_valid(v2), .r(t2)
  );

  // mirror: keep W and the axis component, negate the others
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else if (en) begin
      vm <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mir[0] <= t2[0];
      mir[1] <= (axis == qpm_pkg::AXIS_X) ? t2[1] : -t2[1];
      mir[2] <= (axis == qpm_pkg::AXIS_Y) ? t2[2] : -t2[2];
      mir[3] <= (axis == qpm_pkg::AXIS_Z) ? t2[3] : -t2[3];
    end
  end

  // conj(O) * M
  qpm_hprod #(.AW(CW), .BW(qpm_pkg::Q2W), .RSH(qpm_pkg::RND), .CONJ_A(1'b1)) u_prod3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(vm),
    .a(po3), .b(mir), .out_valid(v3), .r(t3)
  );

  // (conj(O) * M) * O
  qpm_hprod #(.AW(qpm_pkg::Q3W), .BW(CW), .RSH(qpm_pkg::RND)) u_prod4 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3),
    .a(t3), .b(po4), .out_valid(v4), .r(t4)
  );

  qpm_norm u_norm (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4), .m(t4),
    .out_valid(vn), .sum(nsum), .side(nside)
  );

  qpm_sqrt #(.SBW($bits(qpm_pkg::nrm_side_t))) u_sqrt (
    .clk(clk), .rst(rst), .en(en), .in_valid(vn), .sum(nsum), .side_in(nside),
    .out_valid(vs), .root(root), .side_out(rside)
  );

  qpm_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(vs), .root(root), .side(rside),
    .out_valid(vd), .q(qo)
  );

  // output register with a skid register behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      sk_valid <= 1'b0;
    end else if (!o_valid || m_tready) begin
      if (sk_valid) begin
        o_valid <= 1'b1;
        o_data <= sk_data;
        sk_valid <= 1'b0;
      end else begin
        o_valid <= vd;
        o_data <= pdata;
      end
    end else if (vd && !sk_valid) begin
      sk_valid <= 1'b1;
      sk_data <= pdata;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata = o_data;

endmodule

`default_nettype wire
